FILE: hw/rtl/rbvi_pkg.sv
// Shared types, constants and fixed-point helpers of the velocity integrator.
package rbvi_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [30:0] TIME_STEP_RST   = 31'd1092;
    localparam logic [30:0] SPEED_LIMIT_RST = 31'd6553600;

    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_GRAVITY_X   = 3'd1;
    localparam logic [2:0] CFG_GRAVITY_Y   = 3'd2;
    localparam logic [2:0] CFG_SPEED_LIMIT = 3'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int PIPE_DEPTH  = 8;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd30;

    typedef struct packed {
        logic        [30:0] inverse_mass;
        logic        [30:0] body_mass;
        logic signed [31:0] gravity_factor;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] pending_force_x;
        logic signed [31:0] pending_force_y;
        logic        [30:0] linear_damping;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               sleeping;
        logic               last_body;
    } t_body_in;

    typedef struct packed {
        logic signed [31:0] next_vel_x;
        logic signed [31:0] next_vel_y;
        logic signed [31:0] force_delta_x;
        logic signed [31:0] force_delta_y;
        logic               batch_end;
    } t_vel_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic        [30:0] time_step;
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic        [30:0] speed_limit;
    } t_cfg;

    // pipeline record; scratch fields change meaning from stage to stage
    typedef struct packed {
        logic        [30:0] im;
        logic signed [31:0] gfac;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sl;
        logic               last;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] p3;
        logic signed [31:0] p4;
        logic signed [31:0] p5;
        logic        [62:0] q0;
        logic        [62:0] q1;
        logic        [62:0] q2;
    } t_work;

    typedef struct packed {
        logic signed [31:0] nvx;
        logic signed [31:0] nvy;
        logic signed [31:0] fdx;
        logic signed [31:0] fdy;
        logic               last;
        logic               cap;
    } t_qent;

    typedef enum logic [2:0] {
        BK_RUN,
        BK_SQRT,
        BK_PROD,
        BK_DIV,
        BK_DONE
    } t_bk_state;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -64'sh0000000080000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // product with floor shift and saturation
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] subq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat64(64'(a) - 64'(b));
    endfunction

    function automatic logic [31:0] absq(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

FILE: hw/rtl/rbvi_ifs.sv
// Handshake channel interfaces: body input, velocity result, register writes.
interface rbvi_body_if;
    import rbvi_pkg::*;
    logic     valid;
    logic     ready;
    t_body_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbvi_vel_if;
    import rbvi_pkg::*;
    logic     valid;
    logic     ready;
    t_vel_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbvi_cfg_if;
    import rbvi_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rbvi_front.sv
// Front pipeline: force, damping and integration arithmetic, speed-cap test.
module rbvi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbvi_pkg::t_cfg i_cfg,
    rbvi_body_if.sink      i_body,
    input  logic           i_full,
    output logic           o_push,
    output rbvi_pkg::t_qent o_push_data
);
    import rbvi_pkg::*;

    t_work                 r_st [PIPE_DEPTH];
    t_work                 n_st [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0] r_v;
    logic                  w_adv;
    logic                  w_ok;
    logic [31:0]           w_ax;
    logic [31:0]           w_ay;
    logic [63:0]           w_sq;

    // pipeline moves as a whole whenever its tail can leave
    assign w_adv        = !r_v[PIPE_DEPTH-1] || !i_full;
    assign i_body.ready = w_adv;
    assign o_push       = r_v[PIPE_DEPTH-1] && !i_full;

    always_comb begin
        n_st[0] = r_st[0];
        for (int k = 1; k < PIPE_DEPTH; k++) n_st[k] = r_st[k-1];
        w_ok = 1'b0;
        w_ax = '0;
        w_ay = '0;

        // stage 0: gravity*mass, vel*damping, force sums
        n_st[0].im   = i_body.data.inverse_mass;
        n_st[0].gfac = i_body.data.gravity_factor;
        n_st[0].vx   = i_body.data.vel_x;
        n_st[0].vy   = i_body.data.vel_y;
        n_st[0].sl   = i_body.data.sleeping;
        n_st[0].last = i_body.data.last_body;
        n_st[0].p0   = mulq(i_cfg.gravity_x, $signed({1'b0, i_body.data.body_mass}));
        n_st[0].p1   = mulq(i_cfg.gravity_y, $signed({1'b0, i_body.data.body_mass}));
        n_st[0].p2   = mulq(i_body.data.vel_x, $signed({1'b0, i_body.data.linear_damping}));
        n_st[0].p3   = mulq(i_body.data.vel_y, $signed({1'b0, i_body.data.linear_damping}));
        n_st[0].p4   = addq(i_body.data.force_x, i_body.data.pending_force_x);
        n_st[0].p5   = addq(i_body.data.force_y, i_body.data.pending_force_y);

        // stage 1: gravity force, damped force
        n_st[1].p0 = mulq(r_st[0].p0, r_st[0].gfac);
        n_st[1].p1 = mulq(r_st[0].p1, r_st[0].gfac);
        n_st[1].p2 = subq(r_st[0].p4, r_st[0].p2);
        n_st[1].p3 = subq(r_st[0].p5, r_st[0].p3);

        // stage 2: add gravity
        n_st[2].p0 = addq(r_st[1].p4, r_st[1].p0);
        n_st[2].p1 = addq(r_st[1].p5, r_st[1].p1);
        n_st[2].p2 = addq(r_st[1].p2, r_st[1].p0);
        n_st[2].p3 = addq(r_st[1].p3, r_st[1].p1);

        // stage 3: times inverse mass
        n_st[3].p0 = mulq(r_st[2].p0, $signed({1'b0, r_st[2].im}));
        n_st[3].p1 = mulq(r_st[2].p1, $signed({1'b0, r_st[2].im}));
        n_st[3].p2 = mulq(r_st[2].p2, $signed({1'b0, r_st[2].im}));
        n_st[3].p3 = mulq(r_st[2].p3, $signed({1'b0, r_st[2].im}));

        // stage 4: times time step; report delta only for awake movable bodies
        w_ok       = (r_st[3].im != '0) && !r_st[3].sl;
        n_st[4].p0 = w_ok ? mulq(r_st[3].p0, $signed({1'b0, i_cfg.time_step})) : '0;
        n_st[4].p1 = w_ok ? mulq(r_st[3].p1, $signed({1'b0, i_cfg.time_step})) : '0;
        n_st[4].p2 = mulq(r_st[3].p2, $signed({1'b0, i_cfg.time_step}));
        n_st[4].p3 = mulq(r_st[3].p3, $signed({1'b0, i_cfg.time_step}));

        // stage 5: new velocity; a sleeping body keeps its own
        n_st[5].p2 = r_st[4].sl ? r_st[4].vx : addq(r_st[4].vx, r_st[4].p2);
        n_st[5].p3 = r_st[4].sl ? r_st[4].vy : addq(r_st[4].vy, r_st[4].p3);

        // stage 6: squares
        w_ax       = absq(r_st[5].p2);
        w_ay       = absq(r_st[5].p3);
        n_st[6].q0 = 63'(64'(w_ax) * 64'(w_ax));
        n_st[6].q1 = 63'(64'(w_ay) * 64'(w_ay));
        n_st[6].q2 = 63'(64'(i_cfg.speed_limit) * 64'(i_cfg.speed_limit));

        // stage 7 holds the stage 6 record
    end

    assign w_sq = 64'(r_st[PIPE_DEPTH-1].q0) + 64'(r_st[PIPE_DEPTH-1].q1);

    always_comb begin
        o_push_data.nvx  = r_st[PIPE_DEPTH-1].p2;
        o_push_data.nvy  = r_st[PIPE_DEPTH-1].p3;
        o_push_data.fdx  = r_st[PIPE_DEPTH-1].p0;
        o_push_data.fdy  = r_st[PIPE_DEPTH-1].p1;
        o_push_data.last = r_st[PIPE_DEPTH-1].last;
        o_push_data.cap  = !r_st[PIPE_DEPTH-1].sl && (w_sq > 64'(r_st[PIPE_DEPTH-1].q2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_body.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < PIPE_DEPTH; k++) r_st[k] <= n_st[k];
        end
    end

endmodule

FILE: hw/rtl/rbvi_queue.sv
// Small FIFO between the front pipeline and the speed-cap back end.
module rbvi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rbvi_pkg::t_qent i_data,
    input  logic            i_pop,
    output rbvi_pkg::t_qent o_data,
    output logic            o_full,
    output logic            o_empty
);
    import rbvi_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_qent                r_mem [QUEUE_DEPTH];
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_rp;
    logic [AW:0]          r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (AW+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: hw/rtl/rbvi_back.sv
// Back end: speed cap by digit-serial square root and division, output register.
module rbvi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [30:0]     i_speed_limit,
    input  logic            i_empty,
    input  rbvi_pkg::t_qent i_head,
    output logic            o_pop,
    rbvi_vel_if.source      o_vel
);
    import rbvi_pkg::*;

    t_bk_state   r_state, n_state;
    logic        r_ov;
    t_vel_out    r_od;
    logic        w_free;
    logic        w_load_out;
    t_vel_out    w_out;

    // working registers of a capped item
    t_qent       r_it;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic [32:0] r_rx, r_ry;
    logic [30:0] r_lx, r_ly;

    logic [35:0] w_rem2;
    logic [35:0] w_trial;
    logic [32:0] w_tx, w_ty;
    logic [62:0] w_px, w_py;
    logic        w_cap_done;

    assign w_free      = !r_ov || o_vel.ready;
    assign o_vel.valid = r_ov;
    assign o_vel.data  = r_od;

    assign w_rem2  = {r_rem, r_rad[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_tx    = {r_rx[31:0], r_lx[30]};
    assign w_ty    = {r_ry[31:0], r_ly[30]};
    assign w_px    = 63'(64'(absq(r_it.nvx)) * 64'(i_speed_limit));
    assign w_py    = 63'(64'(absq(r_it.nvy)) * 64'(i_speed_limit));

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        w_cap_done = 1'b0;
        w_out      = '0;
        unique case (r_state)
            BK_RUN: begin
                if (!i_empty && w_free) begin
                    o_pop = 1'b1;
                    if (i_head.cap) begin
                        n_state = BK_SQRT;
                    end else begin
                        w_load_out = 1'b1;
                        w_out = '{next_vel_x: i_head.nvx, next_vel_y: i_head.nvy,
                                  force_delta_x: i_head.fdx, force_delta_y: i_head.fdy,
                                  batch_end: i_head.last};
                    end
                end
            end
            BK_SQRT: if (r_cnt == SQRT_LAST) n_state = BK_PROD;
            BK_PROD: n_state = BK_DIV;
            BK_DIV:  if (r_cnt == DIV_LAST) n_state = BK_DONE;
            BK_DONE: begin
                if (w_free) begin
                    w_cap_done = 1'b1;
                    w_load_out = 1'b1;
                    w_out = '{next_vel_x: r_it.nvx[31] ? -$signed({1'b0, r_lx})
                                                       : $signed({1'b0, r_lx}),
                              next_vel_y: r_it.nvy[31] ? -$signed({1'b0, r_ly})
                                                       : $signed({1'b0, r_ly}),
                              force_delta_x: r_it.fdx, force_delta_y: r_it.fdy,
                              batch_end: r_it.last};
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out)       r_ov <= 1'b1;
            else if (o_vel.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) r_od <= w_out;
        unique case (r_state)
            BK_RUN: begin
                r_it   <= i_head;
                r_rad  <= 64'(absq(i_head.nvx)) * 64'(absq(i_head.nvx))
                        + 64'(absq(i_head.nvy)) * 64'(absq(i_head.nvy));
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            BK_SQRT: begin
                // one root bit per cycle
                r_rad <= {r_rad[61:0], 2'b00};
                r_cnt <= r_cnt + 5'd1;
                if (w_rem2 >= w_trial) begin
                    r_rem  <= 34'(w_rem2 - w_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            BK_PROD: begin
                // quotient fits 31 bits, so the high part starts below the root
                r_rx  <= {1'b0, w_px[62:31]};
                r_lx  <= w_px[30:0];
                r_ry  <= {1'b0, w_py[62:31]};
                r_ly  <= w_py[30:0];
                r_cnt <= '0;
            end
            BK_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_tx >= {1'b0, r_root}) begin
                    r_rx <= w_tx - {1'b0, r_root};
                    r_lx <= {r_lx[29:0], 1'b1};
                end else begin
                    r_rx <= w_tx;
                    r_lx <= {r_lx[29:0], 1'b0};
                end
                if (w_ty >= {1'b0, r_root}) begin
                    r_ry <= w_ty - {1'b0, r_root};
                    r_ly <= {r_ly[29:0], 1'b1};
                end else begin
                    r_ry <= w_ty;
                    r_ly <= {r_ly[29:0], 1'b0};
                end
            end
            BK_DONE: begin
                if (w_cap_done) r_cnt <= '0;
            end
            default: r_cnt <= '0;
        endcase
    end

endmodule

FILE: hw/rtl/rigid_body_velocity_integrate.sv
// Top level of the 2D rigid body velocity integrator.
//
// Channels: i_body takes one body record per transfer, o_vel returns one
// result per body in the same order, i_cfg writes the registers time_step,
// gravity_x, gravity_y and speed_limit (index 0 to 3; other indexes are
// dropped). i_cfg is always ready; write it only while no body is in flight.
// A body under the speed limit passes the front pipeline, the queue and
// the output register. A body over the limit also steps through the back
// end in order: square root, multiply, division, then the load of the
// output register.
// One body per cycle enters while no speed cap is needed and o_vel is
// ready; a capped body holds the back end through root and division.
// The eight-stage front pipeline feeds a four-entry queue, so the front
// keeps taking bodies while the back end works or o_vel stalls.
// Reset (synchronous, active low) empties pipeline, queue and output
// register and restores time_step 1092, zero gravity and speed_limit 100.0.
// When o_vel stalls, the result holds in the output register, the queue
// fills, and i_body.ready drops once the pipeline tail cannot move.
module rigid_body_velocity_integrate (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbvi_cfg_if.sink   i_cfg,
    rbvi_body_if.sink  i_body,
    rbvi_vel_if.source o_vel
);
    import rbvi_pkg::*;

    t_cfg  r_cfg;
    logic  w_push, w_pop, w_full, w_empty;
    t_qent w_push_data, w_head;

    assign i_cfg.ready = 1'b1;

    // register file; a write outside the list leaves everything as is
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step   <= TIME_STEP_RST;
            r_cfg.gravity_x   <= '0;
            r_cfg.gravity_y   <= '0;
            r_cfg.speed_limit <= SPEED_LIMIT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.index == CFG_TIME_STEP)   r_cfg.time_step   <= i_cfg.data.wdata[30:0];
            if (i_cfg.data.index == CFG_GRAVITY_X)   r_cfg.gravity_x   <= i_cfg.data.wdata;
            if (i_cfg.data.index == CFG_GRAVITY_Y)   r_cfg.gravity_y   <= i_cfg.data.wdata;
            if (i_cfg.data.index == CFG_SPEED_LIMIT) r_cfg.speed_limit <= i_cfg.data.wdata[30:0];
        end
    end

    rbvi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_body      (i_body),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    rbvi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rbvi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_speed_limit (r_cfg.speed_limit),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_vel         (o_vel)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_head.cap) |=> o_vel.valid)
        else $error("uncapped item did not reach the output register");

endmodule

FILE: sim/tb_rigid_body_velocity_integrate.sv
// Testbench of the 2D rigid body velocity integrator: random and directed bodies, scoreboard.
import rbvi_pkg::*;

class vel_scoreboard;
    // register copies used by the velocity predictor
    bit [30:0]        time_step;
    bit signed [31:0] grav_x;
    bit signed [31:0] grav_y;
    bit [30:0]        speed_limit;
    t_vel_out         pending_vel[$];
    int               errors;
    int               checked;
    int               capped;

    function void reset_regs();
        time_step   = TIME_STEP_RST;
        grav_x      = 0;
        grav_y      = 0;
        speed_limit = SPEED_LIMIT_RST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_TIME_STEP:   time_step = val[30:0];
            CFG_GRAVITY_X:   grav_x = val;
            CFG_GRAVITY_Y:   grav_y = val;
            CFG_SPEED_LIMIT: speed_limit = val[30:0];
            default: ;
        endcase
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact product, floor shift, saturate
    function longint fxmul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function longint unsigned root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint cap_comp(longint v, longint unsigned lim, longint unsigned s);
        longint unsigned m, q;
        m = (v < 0) ? -v : v;
        q = (m * lim) / s;
        return clamp32(v < 0 ? -longint'(q) : longint'(q));
    endfunction

    function void note_body(t_body_in b);
        longint im, dt, vx, vy, gx, gy, tx, ty, fdx, fdy, dx, dy, nvx, nvy;
        longint unsigned ax, ay, sq, lim, s;
        t_vel_out r;
        im  = b.inverse_mass;
        dt  = time_step;
        vx  = b.vel_x;
        vy  = b.vel_y;
        gx  = fxmul(fxmul(grav_x, b.body_mass), b.gravity_factor);
        gy  = fxmul(fxmul(grav_y, b.body_mass), b.gravity_factor);
        tx  = clamp32(longint'(b.force_x) + b.pending_force_x);
        ty  = clamp32(longint'(b.force_y) + b.pending_force_y);
        fdx = 0;
        fdy = 0;
        if (im > 0 && !b.sleeping) begin
            fdx = fxmul(fxmul(clamp32(tx + gx), im), dt);
            fdy = fxmul(fxmul(clamp32(ty + gy), im), dt);
        end
        dx  = clamp32(tx - fxmul(vx, b.linear_damping));
        dy  = clamp32(ty - fxmul(vy, b.linear_damping));
        nvx = clamp32(vx + fxmul(fxmul(clamp32(dx + gx), im), dt));
        nvy = clamp32(vy + fxmul(fxmul(clamp32(dy + gy), im), dt));
        ax  = (nvx < 0) ? -nvx : nvx;
        ay  = (nvy < 0) ? -nvy : nvy;
        sq  = ax * ax + ay * ay;
        lim = speed_limit;
        if (sq > lim * lim) begin
            s = root_floor(sq);
            if (s != 0) begin
                nvx = cap_comp(nvx, lim, s);
                nvy = cap_comp(nvy, lim, s);
            end
            capped++;
        end
        if (b.sleeping) begin
            nvx = vx;
            nvy = vy;
        end
        r.next_vel_x    = nvx[31:0];
        r.next_vel_y    = nvy[31:0];
        r.force_delta_x = fdx[31:0];
        r.force_delta_y = fdy[31:0];
        r.batch_end     = b.last_body;
        pending_vel.push_back(r);
    endfunction

    function void check_vel(t_vel_out got);
        t_vel_out exp_r;
        if (pending_vel.size() == 0) begin
            $display("%0t: result without pending body: %h", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending_vel.pop_front();
        checked++;
        if (got.next_vel_x !== exp_r.next_vel_x) begin
            $display("%0t: next_vel_x exp %h got %h", $realtime, exp_r.next_vel_x,
                     got.next_vel_x);
            errors++;
        end
        if (got.next_vel_y !== exp_r.next_vel_y) begin
            $display("%0t: next_vel_y exp %h got %h", $realtime, exp_r.next_vel_y,
                     got.next_vel_y);
            errors++;
        end
        if (got.force_delta_x !== exp_r.force_delta_x) begin
            $display("%0t: force_delta_x exp %h got %h", $realtime, exp_r.force_delta_x,
                     got.force_delta_x);
            errors++;
        end
        if (got.force_delta_y !== exp_r.force_delta_y) begin
            $display("%0t: force_delta_y exp %h got %h", $realtime, exp_r.force_delta_y,
                     got.force_delta_y);
            errors++;
        end
        if (got.batch_end !== exp_r.batch_end) begin
            $display("%0t: batch_end exp %b got %b", $realtime, exp_r.batch_end,
                     got.batch_end);
            errors++;
        end
    endfunction
endclass

module tb_rigid_body_velocity_integrate;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF       = 600;

    logic i_clk;
    logic i_rst_n;

    rbvi_cfg_if  cfg_ch ();
    rbvi_body_if body_ch ();
    rbvi_vel_if  vel_ch ();

    rigid_body_velocity_integrate u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_body (body_ch.sink),
        .o_vel  (vel_ch.source)
    );

    vel_scoreboard sb;
    int  idle_cycles;
    bit  hold_off_req;   // asks the result side for one long stall
    bit  hold_off_done;
    bit  stall_free;     // stretch with no gaps on either side
    int  bodies_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_s32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
            3: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_u31();
        case ($urandom_range(0, 5))
            0: return 31'h7FFFFFFF;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 32'h0003FFFF));
            3: return 31'($urandom_range(0, 32'h00FFFFFF));
            default: return 31'($urandom);
        endcase
    endfunction

    // plausible body: moderate values that keep most results off saturation
    function automatic t_body_in rand_body();
        t_body_in b;
        if ($urandom_range(0, 3) == 0) begin
            b.inverse_mass    = rand_u31();
            b.body_mass       = rand_u31();
            b.gravity_factor  = rand_s32();
            b.force_x         = rand_s32();
            b.force_y         = rand_s32();
            b.pending_force_x = rand_s32();
            b.pending_force_y = rand_s32();
            b.linear_damping  = rand_u31();
            b.vel_x           = rand_s32();
            b.vel_y           = rand_s32();
        end else begin
            b.inverse_mass    = 31'($urandom_range(0, 32'h00040000));
            b.body_mass       = 31'($urandom_range(0, 32'h00080000));
            b.gravity_factor  = $urandom_range(0, 32'h00040000) - 32'h00010000;
            b.force_x         = $urandom_range(0, 32'h04000000) - 32'h02000000;
            b.force_y         = $urandom_range(0, 32'h04000000) - 32'h02000000;
            b.pending_force_x = $urandom_range(0, 32'h00400000) - 32'h00200000;
            b.pending_force_y = $urandom_range(0, 32'h00400000) - 32'h00200000;
            b.linear_damping  = 31'($urandom_range(0, 32'h00020000));
            b.vel_x           = $urandom_range(0, 32'h0A000000) - 32'h05000000;
            b.vel_y           = $urandom_range(0, 32'h0A000000) - 32'h05000000;
        end
        if ($urandom_range(0, 9) == 0) b.inverse_mass = 0;
        b.sleeping  = ($urandom_range(0, 7) == 0);
        b.last_body = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
    endtask

    // one body transfer; valid stays high straight into the next body when no gap
    task automatic send_body(t_body_in b, bit gaps);
        int g;
        g = gaps && !stall_free ? gap_len() : 0;
        if (g > 0) begin
            body_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        body_ch.valid <= 1'b1;
        body_ch.data  <= b;
        @(posedge i_clk);
        while (!body_ch.ready) @(posedge i_clk);
        sb.note_body(b);
        bodies_sent++;
    endtask

    task automatic end_burst();
        body_ch.valid <= 1'b0;
    endtask

    // idle until every result is back, then let the back end drain fully
    task automatic wait_drained();
        while (sb.pending_vel.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int g;
        vel_ch.ready  = 1'b0;
        hold_off_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                vel_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            g = stall_free ? 0 : gap_len();
            if (g > 0) begin
                vel_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            vel_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // result monitor and watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && vel_ch.valid && vel_ch.ready) sb.check_vel(vel_ch.data);
            if ((vel_ch.valid && vel_ch.ready) || (body_ch.valid && body_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        t_body_in b;
        int n;
        logic [31:0] cfg_sets [0:4][0:3];
        sb = new();
        sb.reset_regs();
        hold_off_req  = 1'b0;
        stall_free    = 1'b0;
        bodies_sent   = 0;
        i_rst_n       = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        body_ch.valid = 1'b0;
        body_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, field extremes, sleeping and immovable bodies
        for (int k = 0; k < 20; k++) begin
            b = '0;
            case (k)
                0: ;
                1: b = '1;
                2: begin
                    b.inverse_mass = 31'h7FFFFFFF; b.force_x = 32'h7FFFFFFF;
                    b.pending_force_x = 32'h7FFFFFFF; b.force_y = 32'h80000000;
                    b.pending_force_y = 32'h80000000;
                end
                3: begin
                    b.inverse_mass = 31'h00010000; b.vel_x = 32'h7FFFFFFF;
                    b.vel_y = 32'h7FFFFFFF; b.linear_damping = 31'h7FFFFFFF;
                end
                4: begin
                    b.inverse_mass = 31'h00010000; b.vel_x = 32'h80000000;
                    b.vel_y = 32'h80000000;
                end
                5: begin  // asleep, fast: velocity passes through
                    b.inverse_mass = 31'h00010000; b.sleeping = 1'b1;
                    b.vel_x = 32'h7FFFFFFF; b.force_x = 32'h01000000;
                end
                6: begin  // immovable body
                    b.force_x = 32'h01000000; b.vel_x = 32'h00640000;
                    b.vel_y = 32'h00010000;
                end
                7: begin  // exactly at the speed limit
                    b.vel_x = 32'h00640000;
                end
                8: begin  // just over the limit
                    b.vel_x = 32'h00640001;
                end
                9: begin
                    b.vel_x = 32'hFF9C0000; b.vel_y = 32'h00500000;
                end
                default: b = rand_body();
            endcase
            b.last_body = (k % 5 == 4);
            send_body(b, 1'b0);
        end
        end_burst();
        wait_drained();

        // register settings, extremes included
        cfg_sets[0] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        cfg_sets[1] = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'd0};
        cfg_sets[2] = '{32'd1092, 32'd0, 32'hFFF63000, 32'd6553600};
        cfg_sets[3] = '{32'h00008000, 32'h00013000, 32'hFFF00000, 32'h00020000};
        cfg_sets[4] = '{32'h00000444, 32'hFFFF0000, 32'hFFF63000, 32'h01000000};
        for (int p = 0; p < 5; p++) begin
            write_cfg(CFG_TIME_STEP, cfg_sets[p][0]);
            write_cfg(CFG_GRAVITY_X, cfg_sets[p][1]);
            write_cfg(CFG_GRAVITY_Y, cfg_sets[p][2]);
            write_cfg(CFG_SPEED_LIMIT, cfg_sets[p][3]);
            write_cfg(3'd7, $urandom);  // unknown index, dropped
            cfg_ch.valid <= 1'b0;
            @(posedge i_clk);
            n = (p == 0) ? 80 : 300;
            stall_free = (p == 2);
            if (p == 3) hold_off_req = 1'b1;  // block fills and stalls its input
            for (int k = 0; k < n; k++) send_body(rand_body(), 1'b1);
            end_burst();
            stall_free = 1'b0;
            wait_drained();  // sender pauses until all results are back
        end

        $display("summary: %0d bodies, %0d results checked, %0d speed-capped",
                 bodies_sent, sb.checked, sb.capped);
        $display("summary: five register settings plus directed extremes, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending_vel.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
